// ===== rtl/core/lcd_progress_bar_glyphs_defines.svh =====
// assertion macros for the progress bar glyph block
// used by the checker; no other dependencies
`ifndef LCD_PROGRESS_BAR_GLYPHS_DEFINES_SVH
`define LCD_PROGRESS_BAR_GLYPHS_DEFINES_SVH

// property checked on every clock edge out of reset
`define LPBG_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// signal holds in the cycle after the condition
`define LPBG_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ===== rtl/core/lpbg_pkg.sv =====
// shared types and constants of the progress bar glyph block
// no dependencies
package lpbg_pkg;

	localparam int MAX_CELLS    = 40;
	localparam int CELL_W       = $clog2(MAX_CELLS + 1);
	localparam int PIX_PER_CELL = 5;
	localparam int PROG_W       = 8;
	localparam int CODE_W       = 3;
	localparam int PROD_W       = 16;
	localparam int MUL_STEPS    = PROG_W;
	localparam int DIV_STEPS    = PROD_W;
	localparam int STEP_W       = 4;
	localparam int ADDR_W       = 3;

	localparam logic [CODE_W-1:0] CODE_EMPTY = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_FULL  = CODE_W'(PIX_PER_CELL);

	// register index, taken from paddr[2]
	localparam logic REG_MAX_PROGRESS = 1'b0;
	localparam logic REG_BAR_LENGTH   = 1'b1;

	localparam logic [PROG_W-1:0] MAX_PROGRESS_RST = 8'd255;
	localparam logic [5:0]        BAR_LENGTH_RST   = 6'd16;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

// ===== rtl/core/lcd_progress_bar_glyphs.sv =====
// Character LCD progress bar glyph generator: one progress word in, one glyph word per cell out.
// Each accepted word is latched, then goes through a bit-serial multiply
// (progress by bar length times 5, one progress bit per cycle) and a
// restoring divide by max_progress (one quotient bit per cycle), then emits one
// cell per cycle while the output is not stalled, bar_length capped at 40. A bar
// length of 0 gives no output words. Input stall is high from acceptance until
// the last cell has been loaded into the output register, or the divide ends if
// there are no cells. Registers: max_progress at byte 0, bar_length at byte 4.
module lcd_progress_bar_glyphs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lpbg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lpbg_pkg::PROG_W-1:0] progress,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lpbg_pkg::CODE_W-1:0] glyph_code,
	output logic                        last_cell
);
	import lpbg_pkg::*;

	logic [PROG_W-1:0] max_progress_q;
	logic [5:0]        bar_length_q;
	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [PROG_W-1:0] prog_q;
	logic [PROG_W-1:0] maxp_q;
	logic [CELL_W-1:0] len_q;
	logic [CELL_W-1:0] cell_q;
	logic [7:0]        start_q;
	logic [PROD_W-1:0] acc_q;
	logic [7:0]        rem_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] glyph_code_q;
	logic              last_cell_q;

	logic              cfg_wr;
	logic              in_take;
	logic              out_take;
	logic              load;
	logic [7:0]        len5;
	logic [8:0]        trial;
	logic              fits;
	logic [8:0]        cell_end;
	logic [7:0]        pixels;
	logic [CODE_W-1:0] code;
	logic              is_last;
	logic [CELL_W-1:0] len_sat;
	logic [PROG_W-1:0] maxp_eff;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == REG_BAR_LENGTH) ? {26'b0, bar_length_q}
		: {24'b0, max_progress_q};

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign len_sat  = (bar_length_q > 6'(MAX_CELLS)) ? CELL_W'(MAX_CELLS)
		: CELL_W'(bar_length_q);
	assign len5     = {len_q, 2'b00} + {2'b00, len_q};

	// a zero maximum acts as one
	assign maxp_eff = (max_progress_q == '0) ? PROG_W'(1) : max_progress_q;

	// restoring divide step
	assign trial    = {rem_q, acc_q[PROD_W-1]};
	assign fits     = trial >= {1'b0, maxp_q};

	// cell classification against the filled pixel count
	assign pixels   = acc_q[7:0];
	assign cell_end = {1'b0, start_q} + 9'(PIX_PER_CELL);
	assign is_last  = (cell_q == len_q - CELL_W'(1));

	always_comb begin
		if (cell_end <= {1'b0, pixels}) begin
			code = CODE_FULL;
		end else if (start_q > pixels) begin
			code = CODE_EMPTY;
		end else begin
			code = CODE_W'(pixels - start_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_progress_q <= MAX_PROGRESS_RST;
			bar_length_q   <= BAR_LENGTH_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAX_PROGRESS: max_progress_q <= pwdata[PROG_W-1:0];
				REG_BAR_LENGTH:   bar_length_q   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= (len_q == '0) ? ST_IDLE : ST_EMIT;
						step_q  <= '0;
					end
				end
				ST_EMIT: begin
					if (load && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					maxp_q <= maxp_eff;
					prog_q <= (progress > maxp_eff) ? maxp_eff : progress;
					len_q  <= len_sat;
					acc_q  <= '0;
				end
			end
			ST_MUL: begin
				// msb first shift and add
				acc_q  <= {acc_q[PROD_W-2:0], 1'b0}
					+ (prog_q[PROG_W-1] ? {8'b0, len5} : PROD_W'(0));
				prog_q <= {prog_q[PROG_W-2:0], 1'b0};
				rem_q  <= '0;
			end
			ST_DIV: begin
				// quotient bits shift into the low end of acc
				rem_q <= fits ? 8'(trial - {1'b0, maxp_q}) : trial[7:0];
				acc_q <= {acc_q[PROD_W-2:0], fits};
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					cell_q  <= '0;
					start_q <= '0;
				end
			end
			ST_EMIT: begin
				if (load) begin
					cell_q  <= cell_q + CELL_W'(1);
					start_q <= start_q + 8'(PIX_PER_CELL);
				end
			end
			default: ;
		endcase
		if (load) begin
			glyph_code_q <= code;
			last_cell_q  <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign glyph_code = glyph_code_q;
	assign last_cell  = last_cell_q;

endmodule

// ===== rtl/core/lpbg_checker.sv =====
// port-level checks for the progress bar glyph block, bound to the top level
// depends on lpbg_pkg and lcd_progress_bar_glyphs_defines.svh
`include "lcd_progress_bar_glyphs_defines.svh"

module lpbg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lpbg_pkg::CODE_W-1:0] glyph_code,
	input logic                        last_cell
);
	import lpbg_pkg::*;

	// a cell never holds more than a full glyph
	`LPBG_ASSERT(a_code_range, clk, arst_n, !out_valid || glyph_code <= CODE_FULL, "glyph code above full")
	// the block is busy right after taking a word
	`LPBG_ASSERT(a_busy_after_take, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "input not stalled after accept")
	// a word always spends cycles computing before its first cell can follow
	`LPBG_ASSERT(a_no_instant_cell, clk, arst_n, (in_valid && !in_stall && !out_valid) |=> !out_valid, "cell appeared right after accept")
	`LPBG_ASSERT_HOLD(a_hold_code, clk, arst_n, out_valid && out_stall, glyph_code, "stalled glyph changed")
	`LPBG_ASSERT_HOLD(a_hold_last, clk, arst_n, out_valid && out_stall, last_cell, "stalled last flag changed")

endmodule

bind lcd_progress_bar_glyphs lpbg_checker u_lpbg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.glyph_code (glyph_code),
	.last_cell  (last_cell)
);

// ===== tb/sv/lcd_progress_bar_glyphs_tb.sv =====
// testbench for the progress bar glyph block: progress words in, one glyph word per cell out
// predicts the glyph words in a small scoreboard class; depends on lpbg_pkg and the block
`timescale 1ns / 1ps
module lcd_progress_bar_glyphs_tb;
	import lpbg_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 80;
	localparam int HOLD_CYCLES     = 400;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 20;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} glyph_word_t;

	class glyph_scoreboard;
		logic [PROG_W-1:0] max_progress;
		logic [5:0]        bar_length;
		glyph_word_t       cells_due[$];
		int unsigned       errors;

		function new();
			max_progress = MAX_PROGRESS_RST;
			bar_length   = BAR_LENGTH_RST;
			errors       = 0;
		endfunction

		// expected glyph words for one accepted progress word
		function void note_progress(logic [PROG_W-1:0] prog);
			int unsigned maxp, len, p, pixels, start, i;
			glyph_word_t w;
			maxp = (max_progress == 0) ? 1 : max_progress;
			len  = (bar_length > MAX_CELLS) ? MAX_CELLS : bar_length;
			p    = (prog > maxp) ? maxp : prog;
			pixels = (p * len * PIX_PER_CELL) / maxp;
			for (i = 0; i < len; i++) begin
				start = i * PIX_PER_CELL;
				if (start + PIX_PER_CELL <= pixels)
					w.code = CODE_FULL;
				else if (start > pixels)
					w.code = CODE_EMPTY;
				else
					w.code = CODE_W'(pixels % PIX_PER_CELL);
				w.last = (i + 1 == len);
				cells_due.push_back(w);
			end
		endfunction

		function void check_cell(logic [CODE_W-1:0] code, logic last);
			glyph_word_t w;
			if (cells_due.size() == 0) begin
				$error("glyph word with none expected: glyph_code %0d last_cell %0d", code, last);
				errors++;
				return;
			end
			w = cells_due.pop_front();
			if (code !== w.code) begin
				$error("glyph_code mismatch: expected %0d, actual %0d", w.code, code);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_cell mismatch: expected %0d, actual %0d", w.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PROG_W-1:0] progress = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CODE_W-1:0] glyph_code;
	logic              last_cell;

	glyph_scoreboard sb = new();
	bit              hold_req = 1'b0;
	int unsigned     cycle_count = 0;

	lcd_progress_bar_glyphs u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.progress  (progress),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.glyph_code(glyph_code),
		.last_cell (last_cell)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_progress(progress);
			if (out_valid && !out_stall)
				sb.check_cell(glyph_code, last_cell);
		end
	end

	// receiver: stall pattern changes every stretch, plus one long hold on request
	initial begin
		int stall_left;
		int stall_mode;
		stall_left = 0;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (stall_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					stall_left = $urandom_range(16, 160);
				end
				stall_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= stall_left[2];
				endcase
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer_progress(input logic [PROG_W-1:0] p);
		in_valid <= 1'b1;
		progress <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_MAX_PROGRESS)
			sb.max_progress = value[PROG_W-1:0];
		else
			sb.bar_length = value[5:0];
	endtask

	// zero-length bars leave no words to wait for, hence the settle time
	task automatic wait_idle();
		while (sb.cells_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input bit do_write, input logic [PROG_W-1:0] maxp,
			input logic [5:0] len, input logic [PROG_W-1:0] vals[$], input int gap_max);
		int burst_left;
		if (do_write) begin
			wait_idle();
			write_reg(REG_MAX_PROGRESS, {24'(0), maxp});
			write_reg(REG_BAR_LENGTH, {26'(0), len});
		end
		burst_left = $urandom_range(1, 8);
		foreach (vals[k]) begin
			offer_progress(vals[k]);
			burst_left--;
			if (burst_left == 0 && gap_max > 0) begin
				pause_sender($urandom_range(1, gap_max));
				burst_left = $urandom_range(1, 8);
			end
		end
		in_valid <= 1'b0;
	endtask

	function automatic logic [PROG_W-1:0] pick_progress();
		logic [PROG_W-1:0] m;
		m = sb.max_progress;
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			1: return m + PROG_W'($urandom_range(0, 2)) - 8'd1;
			2: return PROG_W'(1) << $urandom_range(0, 7);
			3: return PROG_W'($urandom_range(0, 3));
			default: return PROG_W'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [PROG_W-1:0] vals[$];
		logic [PROG_W-1:0] maxp;
		logic [5:0]        len;
		int                pick;
		int                gap_max;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values, then full length, unit and zero maximum, zero and oversized length
		vals = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127};
		run_phase(1'b0, 8'd0, 6'd0, vals, 0);
		vals = '{8'd0, 8'd255, 8'd85, 8'd170};
		run_phase(1'b1, 8'd255, 6'd40, vals, 0);
		vals = '{8'd0, 8'd1, 8'd255};
		run_phase(1'b1, 8'd1, 6'd1, vals, 0);
		vals = '{8'd0, 8'd1, 8'd200};
		run_phase(1'b1, 8'd0, 6'd5, vals, 0);
		vals = '{8'd50, 8'd255};
		run_phase(1'b1, 8'd100, 6'd0, vals, 0);
		vals = '{8'd3, 8'd7, 8'd200};
		run_phase(1'b1, 8'd7, 6'd63, vals, 0);
		vals = '{8'd100, 8'd199, 8'd201};
		run_phase(1'b1, 8'd200, 6'd13, vals, 3);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick = $urandom_range(0, 9);
			maxp = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : PROG_W'($urandom_range(1, 255));
			pick = $urandom_range(0, 9);
			len = (pick == 0) ? 6'd0 :
				(pick == 1) ? 6'($urandom_range(41, 63)) :
				(pick < 4) ? 6'($urandom_range(17, 40)) : 6'($urandom_range(1, 16));
			if (ph == 0) begin
				maxp = 8'd255;
				len  = 6'd40;
			end else if (ph == 2) begin
				len = 6'd12;
			end
			gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 12);
			wait_idle();
			write_reg(REG_MAX_PROGRESS, {24'(0), maxp});
			write_reg(REG_BAR_LENGTH, {26'(0), len});
			vals.delete();
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				vals.push_back(pick_progress());
			// long receiver hold while words keep coming
			if (ph == 2)
				hold_req = 1'b1;
			run_phase(1'b0, maxp, len, vals, gap_max);
		end

		wait_idle();
		if (sb.errors == 0 && sb.cells_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== lcd_progress_bar_glyphs.f =====
+incdir+rtl/core
rtl/core/lpbg_pkg.sv
rtl/core/lcd_progress_bar_glyphs.sv
rtl/core/lpbg_checker.sv
tb/sv/lcd_progress_bar_glyphs_tb.sv
